// ===== src/calendar_clock_counter_core_assert.svh =====
// ---------------------------------------------------------------------------
// Calendar clock counter core: assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_COUNTER_CORE_ASSERT_SVH
`define CALENDAR_CLOCK_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ccc_pkg.sv =====
// ---------------------------------------------------------------------------
// Calendar clock counter package
// Field widths, codes, reset values and the month length table.
// ---------------------------------------------------------------------------
package ccc_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int MONTH_W = 4;
    localparam int VAL_W   = 12;

    localparam int YEAR_BITS_DEF = 12;
    localparam int YEAR_BITS_MAX = 16;
    localparam int YEAR_RESET    = 2014;

    localparam int SECS_PER_MIN   = 60;
    localparam int MINS_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int MONTHS_PER_YR  = 12;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        FIELD_SEC   = 3'd0,
        FIELD_MIN   = 3'd1,
        FIELD_HOUR  = 3'd2,
        FIELD_DAY   = 3'd3,
        FIELD_WDAY  = 3'd4,
        FIELD_MONTH = 3'd5,
        FIELD_YEAR  = 3'd6
    } field_sel_t;

    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   min;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  wday;
        logic [MONTH_W-1:0] month;
    } clock_state_t;

    typedef struct packed {
        logic time_chg;
        logic date_chg;
    } chg_flags_t;

    localparam clock_state_t CLOCK_RESET = '{
        sec:   6'd0,
        min:   6'd25,
        hour:  5'd12,
        day:   5'd17,
        wday:  3'd0,
        month: 4'd12
    };

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MONTH_APR || month == MONTH_JUN ||
            month == MONTH_SEP || month == MONTH_NOV)
        begin
            len = 5'd30;
        end
        else if (month == MONTH_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// ===== src/calendar_clock_counter_core.sv =====
// ---------------------------------------------------------------------------
// Calendar clock counter core
// Seconds-to-years clock/calendar driven by tick and field-write requests.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): each request is a one-second tick
// (command = tick) or a write of one field chosen by field_select.
// Output channel (out_valid / out_stall): one result per request, carrying
// the full time/date after that request plus time_changed and date_changed.
// Pipeline: input register, then the state/result register. Throughput:
// one request per cycle unless out_stall holds a result; the update logic
// between the two registers is a single short carry chain.
// Reset: both stages empty, time 12:25:00, day 17, month 12, year 2014,
// weekday 0.
// Stall: while out_stall holds a result, the result and the clock state stay
// put; one more request can wait in the input register, after which
// in_stall rises. in_stall is never high while the output register is empty.
// ---------------------------------------------------------------------------
module calendar_clock_counter_core
    import ccc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [2:0]           field_select,
    input  logic [VAL_W-1:0]     set_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SEC_W-1:0]     seconds_now,
    output logic [MIN_W-1:0]     minutes_now,
    output logic [HOUR_W-1:0]    hours_now,
    output logic [DAY_W-1:0]     day_now,
    output logic [WDAY_W-1:0]    weekday_now,
    output logic [MONTH_W-1:0]   month_now,
    output logic [YEAR_BITS-1:0] year_now,
    output logic                 time_changed,
    output logic                 date_changed
);

    logic                 in_valid_reg;
    logic                 cmd_reg;
    logic [2:0]           sel_reg;
    logic [VAL_W-1:0]     val_reg;
    logic                 out_valid_reg;
    clock_state_t         state_reg;
    clock_state_t         state_next;
    logic [YEAR_BITS-1:0] year_reg;
    logic [YEAR_BITS-1:0] year_next;
    chg_flags_t           flags_reg;
    chg_flags_t           flags_next;
    logic                 advance;
    logic                 move;
    logic                 in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign move     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    ccc_update #(
        .YEAR_BITS (YEAR_BITS)
    ) u_update (
        .cmd      (cmd_reg),
        .sel      (sel_reg),
        .val      (val_reg),
        .cur      (state_reg),
        .year_cur (year_reg),
        .nxt      (state_next),
        .year_nxt (year_next),
        .flags    (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= CLOCK_RESET;
            year_reg      <= YEAR_BITS'(YEAR_RESET);
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
                year_reg  <= year_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= command;
            sel_reg <= field_select;
            val_reg <= set_value;
        end
        if (move)
        begin
            flags_reg <= flags_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign seconds_now  = state_reg.sec;
    assign minutes_now  = state_reg.min;
    assign hours_now    = state_reg.hour;
    assign day_now      = state_reg.day;
    assign weekday_now  = state_reg.wday;
    assign month_now    = state_reg.month;
    assign year_now     = year_reg;
    assign time_changed = flags_reg.time_chg;
    assign date_changed = flags_reg.date_chg;

endmodule

// ===== src/ccc_update.sv =====
// ---------------------------------------------------------------------------
// Calendar clock counter update logic
// Next clock/calendar state and change flags for one request.
// ---------------------------------------------------------------------------
module ccc_update
    import ccc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input  logic                 cmd,
    input  logic [2:0]           sel,
    input  logic [VAL_W-1:0]     val,
    input  clock_state_t         cur,
    input  logic [YEAR_BITS-1:0] year_cur,
    output clock_state_t         nxt,
    output logic [YEAR_BITS-1:0] year_nxt,
    output chg_flags_t           flags
);

    logic [YEAR_BITS_MAX-1:0] val_wide;
    logic [YEAR_BITS-1:0]     year_val;

    assign val_wide = {{(YEAR_BITS_MAX-VAL_W){1'b0}}, val};
    assign year_val = val_wide[YEAR_BITS-1:0];

    always_comb
    begin
        logic [SEC_W:0]   s;
        logic [MIN_W:0]   m;
        logic [HOUR_W:0]  h;
        logic [DAY_W:0]   d;
        logic [MONTH_W:0] mo;
        logic             leap;

        nxt      = cur;
        year_nxt = year_cur;
        flags    = '0;
        s        = {1'b0, cur.sec} + (SEC_W+1)'(1);
        m        = {1'b0, cur.min};
        h        = {1'b0, cur.hour};
        d        = {1'b0, cur.day};
        mo       = {1'b0, cur.month};
        leap     = (year_cur[1:0] == 2'b00);

        if (cmd == CMD_TICK)
        begin
            flags.time_chg = 1'b1;
            if (s >= (SEC_W+1)'(SECS_PER_MIN))
            begin
                s = '0;
                m = m + (MIN_W+1)'(1);
            end
            if (m >= (MIN_W+1)'(MINS_PER_HOUR))
            begin
                m = '0;
                h = h + (HOUR_W+1)'(1);
            end
            if (h >= (HOUR_W+1)'(HOURS_PER_DAY))
            begin
                h = '0;
                d = d + (DAY_W+1)'(1);
                flags.date_chg = 1'b1;
            end
            if (d > {1'b0, month_length(cur.month, leap)})
            begin
                d  = (DAY_W+1)'(1);
                mo = mo + (MONTH_W+1)'(1);
                flags.date_chg = 1'b1;
            end
            if (mo > (MONTH_W+1)'(MONTHS_PER_YR))
            begin
                mo       = (MONTH_W+1)'(1);
                year_nxt = year_cur + YEAR_BITS'(1);
                flags.date_chg = 1'b1;
            end
            nxt.sec   = s[SEC_W-1:0];
            nxt.min   = m[MIN_W-1:0];
            nxt.hour  = h[HOUR_W-1:0];
            nxt.day   = d[DAY_W-1:0];
            nxt.month = mo[MONTH_W-1:0];
        end
        else
        begin
            unique case (sel)
                FIELD_SEC:
                begin
                    nxt.sec        = val[SEC_W-1:0];
                    flags.time_chg = (val[SEC_W-1:0] != cur.sec);
                end
                FIELD_MIN:
                begin
                    nxt.min        = val[MIN_W-1:0];
                    flags.time_chg = (val[MIN_W-1:0] != cur.min);
                end
                FIELD_HOUR:
                begin
                    nxt.hour       = val[HOUR_W-1:0];
                    flags.time_chg = (val[HOUR_W-1:0] != cur.hour);
                end
                FIELD_DAY:
                begin
                    nxt.day        = val[DAY_W-1:0];
                    flags.date_chg = (val[DAY_W-1:0] != cur.day);
                end
                FIELD_WDAY:
                begin
                    nxt.wday       = val[WDAY_W-1:0];
                    flags.date_chg = (val[WDAY_W-1:0] != cur.wday);
                end
                FIELD_MONTH:
                begin
                    nxt.month      = val[MONTH_W-1:0];
                    flags.date_chg = (val[MONTH_W-1:0] != cur.month);
                end
                FIELD_YEAR:
                begin
                    year_nxt       = year_val;
                    flags.date_chg = (year_val != year_cur);
                end
                default:
                begin
                    // unused select: write ignored
                    flags = '0;
                end
            endcase
        end
    end

endmodule

// ===== src/ccc_checker.sv =====
// ---------------------------------------------------------------------------
// Calendar clock counter checker
// Port-level properties of the core, bound to the top level.
// ---------------------------------------------------------------------------
`include "calendar_clock_counter_core_assert.svh"

module ccc_checker
    import ccc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [SEC_W-1:0]     seconds_now,
    input logic [MIN_W-1:0]     minutes_now,
    input logic [HOUR_W-1:0]    hours_now,
    input logic [DAY_W-1:0]     day_now,
    input logic [WDAY_W-1:0]    weekday_now,
    input logic [MONTH_W-1:0]   month_now,
    input logic [YEAR_BITS-1:0] year_now,
    input logic                 time_changed,
    input logic                 date_changed
);

    // held result keeps its payload
    `CCC_ASSERT_NXT(a_hold_result, out_valid && out_stall, out_valid && $stable(seconds_now) && $stable(minutes_now) && $stable(hours_now) && $stable(day_now) && $stable(weekday_now) && $stable(month_now) && $stable(year_now) && $stable(time_changed) && $stable(date_changed), "result changed while stalled")

    // result leaves only when taken
    `CCC_ASSERT_IMP(a_drop_taken, $fell(out_valid), $past(!out_stall), "result dropped without being taken")

    // back-pressure only comes from a held result
    `CCC_ASSERT_IMP(a_stall_source, in_stall, out_valid && out_stall, "input stalled with output free")

    // a tick that changes the date has just rolled hour, day or month
    `CCC_ASSERT_IMP(a_rollover, out_valid && time_changed && date_changed, hours_now == 5'd0 || day_now == 5'd1 || month_now == 4'd1, "date change without rollover")

endmodule

bind calendar_clock_counter_core ccc_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_ccc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .seconds_now  (seconds_now),
    .minutes_now  (minutes_now),
    .hours_now    (hours_now),
    .day_now      (day_now),
    .weekday_now  (weekday_now),
    .month_now    (month_now),
    .year_now     (year_now),
    .time_changed (time_changed),
    .date_changed (date_changed)
);

// ===== bench/calendar_clock_counter_core_tb.sv =====
// ---------------------------------------------------------------------------
// Calendar clock counter core testbench
// Drives tick and field-write requests through the valid/stall input channel,
// tracks the expected clock and calendar in a local model, and compares every
// result field. Random gaps and stalls on both sides, one long output hold.
// ---------------------------------------------------------------------------
module calendar_clock_counter_core_tb;
    import ccc_pkg::*;

    localparam int YEAR_BITS = YEAR_BITS_DEF;
    localparam logic [2:0] FIELD_NONE = 3'd7;
    localparam int RANDOM_REQS = 700;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        cmd_t             cmd;
        logic [2:0]       sel;
        logic [VAL_W-1:0] val;
    } clock_req_t;

    typedef struct {
        clock_state_t         st;
        logic [YEAR_BITS-1:0] year;
        chg_flags_t           flags;
    } calendar_view_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 command = 1'b0;
    logic [2:0]           field_select = '0;
    logic [VAL_W-1:0]     set_value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SEC_W-1:0]     seconds_now;
    logic [MIN_W-1:0]     minutes_now;
    logic [HOUR_W-1:0]    hours_now;
    logic [DAY_W-1:0]     day_now;
    logic [WDAY_W-1:0]    weekday_now;
    logic [MONTH_W-1:0]   month_now;
    logic [YEAR_BITS-1:0] year_now;
    logic                 time_changed;
    logic                 date_changed;

    clock_req_t     req_q[$];
    calendar_view_t calendar_q[$];

    clock_state_t         cal = CLOCK_RESET;
    logic [YEAR_BITS-1:0] cal_year = YEAR_BITS'(YEAR_RESET);

    int  req_count = 0;
    int  fail_cnt = 0;
    int  results_seen = 0;
    int  tx_gap = 0;
    int  tx_calm = 0;
    int  rx_stall_left = 0;
    int  rx_calm = 0;
    bit  tx_busy;
    bit  rx_next;
    logic hold_off = 1'b0;
    logic hold_done = 1'b0;
    int  hold_cnt = 0;

    calendar_clock_counter_core #(
        .YEAR_BITS(YEAR_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .field_select(field_select),
        .set_value(set_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .seconds_now(seconds_now),
        .minutes_now(minutes_now),
        .hours_now(hours_now),
        .day_now(day_now),
        .weekday_now(weekday_now),
        .month_now(month_now),
        .year_now(year_now),
        .time_changed(time_changed),
        .date_changed(date_changed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, some long ones, and calm stretches with none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic calendar_view_t advance_calendar(input clock_req_t rq);
        calendar_view_t   r;
        logic [SEC_W:0]   s;
        logic [MIN_W:0]   m;
        logic [HOUR_W:0]  h;
        logic [DAY_W:0]   d;
        logic [MONTH_W:0] mo;
        int unsigned      days_in_month;
        r.flags = '0;
        if (rq.cmd == CMD_TICK)
        begin
            r.flags.time_chg = 1'b1;
            s = {1'b0, cal.sec} + (SEC_W+1)'(1);
            m = {1'b0, cal.min};
            h = {1'b0, cal.hour};
            d = {1'b0, cal.day};
            mo = {1'b0, cal.month};
            case (cal.month)
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days_in_month = 30;
                MONTH_FEB: days_in_month = (cal_year[1:0] == 2'b00) ? 29 : 28;
                default: days_in_month = 31;
            endcase
            if (s >= SECS_PER_MIN)
            begin
                s = '0;
                m++;
            end
            if (m >= MINS_PER_HOUR)
            begin
                m = '0;
                h++;
            end
            if (h >= HOURS_PER_DAY)
            begin
                h = '0;
                d++;
                r.flags.date_chg = 1'b1;
            end
            if (d > days_in_month)
            begin
                d = (DAY_W+1)'(1);
                mo++;
                r.flags.date_chg = 1'b1;
            end
            if (mo > MONTHS_PER_YR)
            begin
                mo = (MONTH_W+1)'(1);
                cal_year = cal_year + YEAR_BITS'(1);
                r.flags.date_chg = 1'b1;
            end
            cal.sec = s[SEC_W-1:0];
            cal.min = m[MIN_W-1:0];
            cal.hour = h[HOUR_W-1:0];
            cal.day = d[DAY_W-1:0];
            cal.month = mo[MONTH_W-1:0];
        end
        else
        begin
            case (rq.sel)
                FIELD_SEC:
                begin
                    r.flags.time_chg = (cal.sec != rq.val[SEC_W-1:0]);
                    cal.sec = rq.val[SEC_W-1:0];
                end
                FIELD_MIN:
                begin
                    r.flags.time_chg = (cal.min != rq.val[MIN_W-1:0]);
                    cal.min = rq.val[MIN_W-1:0];
                end
                FIELD_HOUR:
                begin
                    r.flags.time_chg = (cal.hour != rq.val[HOUR_W-1:0]);
                    cal.hour = rq.val[HOUR_W-1:0];
                end
                FIELD_DAY:
                begin
                    r.flags.date_chg = (cal.day != rq.val[DAY_W-1:0]);
                    cal.day = rq.val[DAY_W-1:0];
                end
                FIELD_WDAY:
                begin
                    r.flags.date_chg = (cal.wday != rq.val[WDAY_W-1:0]);
                    cal.wday = rq.val[WDAY_W-1:0];
                end
                FIELD_MONTH:
                begin
                    r.flags.date_chg = (cal.month != rq.val[MONTH_W-1:0]);
                    cal.month = rq.val[MONTH_W-1:0];
                end
                FIELD_YEAR:
                begin
                    r.flags.date_chg = (cal_year != rq.val[YEAR_BITS-1:0]);
                    cal_year = rq.val[YEAR_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
        r.st = cal;
        r.year = cal_year;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic put_req(input cmd_t c, input logic [2:0] s, input logic [VAL_W-1:0] v);
        clock_req_t rq;
        rq.cmd = c;
        rq.sel = s;
        rq.val = v;
        req_q.push_back(rq);
        if (!(c == CMD_WRITE && s == FIELD_NONE))
            req_count++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_TICK;
            field_select <= '0;
            set_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                calendar_q.push_back(advance_calendar(req_q.pop_front()));
                tx_busy = 1'b0;
            end
            else
            begin
                tx_busy = in_valid;
            end
            if (!tx_busy)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    command <= req_q[0].cmd;
                    field_select <= req_q[0].sel;
                    set_value <= req_q[0].val;
                    tx_gap = idle_len(tx_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        calendar_view_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (calendar_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want = calendar_q.pop_front();
                    check_field("seconds_now", want.st.sec, seconds_now);
                    check_field("minutes_now", want.st.min, minutes_now);
                    check_field("hours_now", want.st.hour, hours_now);
                    check_field("day_now", want.st.day, day_now);
                    check_field("weekday_now", want.st.wday, weekday_now);
                    check_field("month_now", want.st.month, month_now);
                    check_field("year_now", want.year, year_now);
                    check_field("time_changed", want.flags.time_chg, time_changed);
                    check_field("date_changed", want.flags.date_chg, date_changed);
                end
            end
            rx_next = 1'b0;
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                rx_next = 1'b1;
            end
            else
            begin
                rx_stall_left = idle_len(rx_calm);
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    rx_next = 1'b1;
                end
            end
            out_stall <= hold_off || rx_next;
        end
    end

    // one long output hold so the pipeline backs up into in_stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt <= 0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_off <= (hold_cnt != HOLD_CYCLES - 1);
            hold_done <= (hold_cnt == HOLD_CYCLES - 1);
            hold_cnt <= hold_cnt + 1;
        end
    end

    initial
    begin
        logic [VAL_W-1:0] v;
        int base;
        int n;

        // carry from seconds up to the year, seconds past width, year wrap
        put_req(CMD_WRITE, FIELD_SEC, 12'hFFF);
        put_req(CMD_TICK, FIELD_NONE, 12'hFFF);
        put_req(CMD_WRITE, FIELD_MIN, 12'd59);
        put_req(CMD_WRITE, FIELD_HOUR, 12'd23);
        put_req(CMD_WRITE, FIELD_SEC, 12'd59);
        put_req(CMD_WRITE, FIELD_DAY, 12'd31);
        put_req(CMD_WRITE, FIELD_YEAR, 12'hFFF);
        put_req(CMD_TICK, FIELD_SEC, 12'h000);
        // weekday write, equal write, unused select
        put_req(CMD_WRITE, FIELD_WDAY, 12'hFFF);
        put_req(CMD_WRITE, FIELD_WDAY, 12'd7);
        put_req(CMD_WRITE, FIELD_NONE, 12'hFFF);
        // month above 12 rolls without day carry
        put_req(CMD_WRITE, FIELD_MONTH, 12'd15);
        put_req(CMD_TICK, FIELD_YEAR, 12'hAAA);
        // month 0 keeps 31 days
        put_req(CMD_WRITE, FIELD_MONTH, 12'd0);
        put_req(CMD_WRITE, FIELD_DAY, 12'd31);
        put_req(CMD_TICK, FIELD_DAY, 12'h555);
        // leap February, out-of-range hour
        put_req(CMD_WRITE, FIELD_MONTH, 12'd2);
        put_req(CMD_WRITE, FIELD_YEAR, 12'd2016);
        put_req(CMD_WRITE, FIELD_DAY, 12'd29);
        put_req(CMD_WRITE, FIELD_HOUR, 12'hFFF);
        put_req(CMD_TICK, FIELD_HOUR, 12'd0);
        // common-year February with day 29, then a tick that rolls into March
        put_req(CMD_WRITE, FIELD_YEAR, 12'd2015);
        put_req(CMD_WRITE, FIELD_DAY, 12'd29);
        put_req(CMD_WRITE, FIELD_MONTH, 12'd2);
        put_req(CMD_TICK, FIELD_MONTH, 12'd0);

        base = req_count;
        while (req_count < base + RANDOM_REQS)
        begin
            n = $urandom_range(0, 99);
            if (n < 45)
            begin
                for (int f = 0; f < 7; f++)
                begin
                    if ($urandom_range(0, 2) != 0)
                    begin
                        case (field_sel_t'(f))
                            FIELD_SEC:
                                v = VAL_W'(($urandom() << SEC_W) | $urandom_range(56, 63));
                            FIELD_MIN:
                                v = VAL_W'(($urandom() << MIN_W) | $urandom_range(57, 63));
                            FIELD_HOUR:
                                v = VAL_W'(($urandom() << HOUR_W) | $urandom_range(21, 31));
                            FIELD_DAY:
                                v = VAL_W'(($urandom() << DAY_W) | $urandom_range(26, 31));
                            FIELD_MONTH:
                                v = VAL_W'(($urandom() << MONTH_W) | $urandom_range(0, 15));
                            FIELD_YEAR:
                                v = ($urandom_range(0, 3) == 0) ? 12'hFFF : VAL_W'($urandom());
                            default:
                                v = VAL_W'($urandom());
                        endcase
                        put_req(CMD_WRITE, 3'(f), v);
                    end
                end
                repeat ($urandom_range(1, 6))
                    put_req(CMD_TICK, 3'($urandom_range(0, 7)), VAL_W'($urandom()));
            end
            else if (n < 80)
            begin
                repeat ($urandom_range(1, 10))
                    put_req(CMD_TICK, 3'($urandom_range(0, 7)), VAL_W'($urandom()));
            end
            else
            begin
                put_req(CMD_WRITE, 3'($urandom_range(0, 7)), VAL_W'($urandom()));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid)
            @(posedge clk);
        while (calendar_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ccc_pkg.sv
src/ccc_update.sv
src/calendar_clock_counter_core.sv
src/ccc_checker.sv
bench/calendar_clock_counter_core_tb.sv
